[design/bcmp_pkg.sv]
package bcmp_pkg;

    localparam int MOD_W     = 31;
    localparam int PROD_W    = 2 * MOD_W;
    localparam int DIV_CNT_W = 6;
    localparam int OUT_W     = 32;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [MOD_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [PROD_W-1:0] quo;
        logic [MOD_W-1:0]  rem;
    } t_div_rsp;

endpackage

[design/binomial_coefficient_mod_prime_top.sv]
// Special cases (n equals r, r exceeds n, r is 0 or the modulus is below 2) skip the loop.
// Otherwise up to min(r, n-r) factor steps run, each a multiply, a reduction, a Euclid
// inverse and a second multiply and reduction; every divide goes through one
// 62-step shift-subtract divider. One item at a time: s_axis_tready
// is high only while the sequencer is idle. Reset (i_rst_n low, synchronous) clears
// control and output valid and loads the modulus with 1000000007.
module binomial_coefficient_mod_prime_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration: modulus
    input  logic                                  i_cfg_wr_en,
    input  logic [bcmp_pkg::MOD_W-1:0]            i_cfg_wr_data,
    // tdata fields from bit 0: set_size, choose_count, zero fill
    input  logic [((2*COUNT_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata fields from bit 0: value, zero fill
    output logic [bcmp_pkg::OUT_W-1:0]            o_m_axis_tdata,
    // tuser fields from bit 0: bad_request
    output logic                                  o_m_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready
);

    localparam int MW = bcmp_pkg::MOD_W;
    localparam int PW = bcmp_pkg::PROD_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL1   = 4'd1;
    localparam logic [3:0] S_RED1   = 4'd2;
    localparam logic [3:0] S_WRED1  = 4'd3;
    localparam logic [3:0] S_EU     = 4'd4;
    localparam logic [3:0] S_EUWAIT = 4'd5;
    localparam logic [3:0] S_EUUPD  = 4'd6;
    localparam logic [3:0] S_MUL2   = 4'd7;
    localparam logic [3:0] S_RED2   = 4'd8;
    localparam logic [3:0] S_WRED2  = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0]            r_state, n_state;
    logic [MW-1:0]         r_mod, n_mod;
    logic [COUNT_BITS-1:0] r_n, n_n;
    logic [COUNT_BITS-1:0] r_i, n_i;
    logic [COUNT_BITS-1:0] r_steps, n_steps;
    logic [MW-1:0]         r_x, n_x;
    logic [MW-1:0]         r_num, n_num;
    logic [MW-1:0]         r_a, n_a;
    logic [MW-1:0]         r_erem, n_erem;
    logic [MW:0]           r_cur, n_cur;
    logic [MW:0]           r_prev, n_prev;
    logic                  r_odd, n_odd;
    logic [MW-1:0]         r_inv, n_inv;
    logic [2*MW+1:0]       r_prod, n_prod;
    logic [MW-1:0]         r_res, n_res;
    logic                  r_bad, n_bad;
    logic                  r_ovalid, n_ovalid;
    logic [MW-1:0]         r_oval, n_oval;
    logic                  r_obad, n_obad;

    logic [COUNT_BITS-1:0] in_n, in_r, in_diff;
    logic [MW:0]           prev_red;
    logic [MW-1:0]         inv_val;

    bcmp_pkg::t_div_req    div_req;
    bcmp_pkg::t_div_rsp    div_rsp;

    bcmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_n    = i_s_axis_tdata[COUNT_BITS-1:0];
    assign in_r    = i_s_axis_tdata[2*COUNT_BITS-1:COUNT_BITS];
    assign in_diff = in_n - in_r;

    // Final convergent: reduce prev below the modulus, negate on even step count.
    assign prev_red = (r_prev >= {1'b0, r_mod}) ? (r_prev - {1'b0, r_mod}) : r_prev;
    assign inv_val  = r_odd ? prev_red[MW-1:0]
                    : ((prev_red == '0) ? '0 : (r_mod - prev_red[MW-1:0]));

    // Divider requests: reduce the product by the modulus, or one Euclid quotient.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_prod[PW-1:0];
        div_req.divisor  = r_mod;
        case (r_state)
            S_RED1, S_RED2: begin
                div_req.start = 1'b1;
            end
            S_EU: begin
                div_req.start    = (r_a != '0);
                div_req.dividend = {{(PW-MW){1'b0}}, r_num};
                div_req.divisor  = r_a;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_mod    = r_mod;
        n_n      = r_n;
        n_i      = r_i;
        n_steps  = r_steps;
        n_x      = r_x;
        n_num    = r_num;
        n_a      = r_a;
        n_erem   = r_erem;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_odd    = r_odd;
        n_inv    = r_inv;
        n_prod   = r_prod;
        n_res    = r_res;
        n_bad    = r_bad;
        n_oval   = r_oval;
        n_obad   = r_obad;
        n_ovalid = r_ovalid;

        // drop the output once the downstream side takes it
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        if (i_cfg_wr_en) begin
            n_mod = i_cfg_wr_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_res   = '0;
                    n_bad   = 1'b0;
                    n_n     = in_n;
                    n_i     = COUNT_BITS'(1);
                    n_x     = MW'(1);
                    n_steps = (in_diff > in_r) ? in_r : in_diff;
                    if (in_n == in_r) begin
                        n_res   = MW'(1);
                        n_state = S_FIN;
                    end else if (in_r > in_n) begin
                        n_bad   = 1'b1;
                        n_state = S_FIN;
                    end else if (r_mod < MW'(2)) begin
                        n_state = S_FIN;
                    end else if (in_r == '0 || in_diff == '0) begin
                        n_res   = MW'(1);
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                n_prod  = {1'b0, r_x} * {{(MW+1-COUNT_BITS){1'b0}}, r_n};
                n_state = S_RED1;
            end
            S_RED1: begin
                n_state = S_WRED1;
            end
            S_WRED1: begin
                if (div_rsp.done) begin
                    n_x     = div_rsp.rem;
                    n_num   = r_mod;
                    n_a     = {{(MW-COUNT_BITS){1'b0}}, r_i};
                    n_cur   = (MW+1)'(1);
                    n_prev  = '0;
                    n_odd   = 1'b0;
                    n_state = S_EU;
                end
            end
            S_EU: begin
                if (r_a == '0) begin
                    n_inv   = inv_val;
                    n_state = S_MUL2;
                end else begin
                    n_state = S_EUWAIT;
                end
            end
            S_EUWAIT: begin
                if (div_rsp.done) begin
                    n_prod  = div_rsp.quo[MW:0] * r_cur;
                    n_erem  = div_rsp.rem;
                    n_state = S_EUUPD;
                end
            end
            S_EUUPD: begin
                // advance the convergent: next = q * cur + prev
                n_cur   = r_prod[MW:0] + r_prev;
                n_prev  = r_cur;
                n_num   = r_a;
                n_a     = r_erem;
                n_odd   = !r_odd;
                n_state = S_EU;
            end
            S_MUL2: begin
                n_prod  = {1'b0, r_x} * {1'b0, r_inv};
                n_state = S_RED2;
            end
            S_RED2: begin
                n_state = S_WRED2;
            end
            S_WRED2: begin
                if (div_rsp.done) begin
                    n_x     = div_rsp.rem;
                    n_n     = r_n - 1'b1;
                    n_i     = r_i + 1'b1;
                    n_steps = r_steps - 1'b1;
                    if (r_steps == COUNT_BITS'(1) || div_rsp.rem == '0) begin
                        n_res   = div_rsp.rem;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (!r_ovalid || i_m_axis_tready) begin
                    n_oval   = r_res;
                    n_obad   = r_bad;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mod    <= bcmp_pkg::MODULUS_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mod    <= n_mod;
            r_ovalid <= n_ovalid;
        end
        r_n     <= n_n;
        r_i     <= n_i;
        r_steps <= n_steps;
        r_x     <= n_x;
        r_num   <= n_num;
        r_a     <= n_a;
        r_erem  <= n_erem;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_odd   <= n_odd;
        r_inv   <= n_inv;
        r_prod  <= n_prod;
        r_res   <= n_res;
        r_bad   <= n_bad;
        r_oval  <= n_oval;
        r_obad  <= n_obad;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{(bcmp_pkg::OUT_W-MW){1'b0}}, r_oval};
    assign o_m_axis_tuser  = r_obad;

`ifndef SYNTHESIS
    a_x_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1) |-> (r_x < r_mod))
        else $error("running product not reduced");
    a_steps_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1) |-> (r_steps != '0))
        else $error("factor step with no steps left");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_obad) |-> (r_oval == '0))
        else $error("bad request with nonzero value");
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
`endif

endmodule

[design/bcmp_div.sv]
module bcmp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcmp_pkg::t_div_req i_req,
    output bcmp_pkg::t_div_rsp o_rsp
);

    logic [bcmp_pkg::PROD_W-1:0]    r_quo, n_quo;
    logic [bcmp_pkg::MOD_W-1:0]     r_rem, n_rem;
    logic [bcmp_pkg::MOD_W-1:0]     r_dvs, n_dvs;
    logic [bcmp_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [bcmp_pkg::MOD_W:0]       trial;
    logic [bcmp_pkg::MOD_W:0]       diff;
    logic                           fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial = {r_rem, r_quo[bcmp_pkg::PROD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (r_busy) begin
            n_quo = {r_quo[bcmp_pkg::PROD_W-2:0], fits};
            n_rem = fits ? diff[bcmp_pkg::MOD_W-1:0] : trial[bcmp_pkg::MOD_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == bcmp_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = bcmp_pkg::DIV_CNT_W'(bcmp_pkg::PROD_W);
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && !r_busy) |=> r_busy)
        else $error("divider did not start");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("remainder not below divisor");
`endif

endmodule
